// ===== rtl/spcc_pkg.sv =====
// Shared types and constants for the sensor-pair line parser and scaler.
// No dependencies; imported by sensor_pair_line_to_cc_scaler_top.
package spcc_pkg;

   // character codes
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   // configuration registers
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX = 4'd1;
   localparam int CFG_W = 16;
   localparam logic [CFG_W-1:0] MIN_RESET = 16'd0;
   localparam logic [CFG_W-1:0] MAX_RESET = 16'd1000;

   // control value scaling
   localparam int CC_BITS = 7;
   localparam logic [CC_BITS-1:0] CC_TOP = 7'd127;
   localparam int CNT_W = 3;
   localparam logic [CNT_W-1:0] DIV_LAST = 3'd6;   // CC_BITS quotient bits, 0..6

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_STOP
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/sensor_pair_line_to_cc_scaler_top.sv =====
// Sensor-pair line parser and control-value scaler, top level.
// Depends on spcc_pkg (types, character codes, register indexes).
//
// Usage:
//   req_*  : one received ASCII byte per beat. Lines look like "a,b\n".
//            Fields are decimal, leading spaces skipped, optional minus,
//            parsing of a field stops at the first other character.
//   rsp_*  : one beat per reported field. tuser = channel (0 left, 1 right),
//            tdata = scaled value 0..127, tlast marks the last beat of a line.
//   csr_*  : register writes, index 0 = sensor_min, 1 = sensor_max; other
//            indexes are ignored. Always ready. Write only while idle.
// Timing:
//   Ordinary bytes are taken one per cycle while the sequencer is idle. A
//   line feed that reports fields holds req_tready low while each reported
//   field is scaled (prepare, multiply by 127, 7 restoring-division steps,
//   load output); a clamped field or an empty range skips straight to load.
//   A line feed that reports nothing leaves req_tready high.
// Stall: the result sits in an output register; a stalled receiver holds
//   the sequencer in its load step, while bytes are accepted again as soon
//   as the last result of a line has entered the output register.
// Reset: synchronous, active high; clears line state, restores
//   sensor_min = 0, sensor_max = 1000, and drops rsp_tvalid.
module sensor_pair_line_to_cc_scaler_top
   import spcc_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,    // [7:0] rx_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,    // [6:0] cc_value, [7] zero
   output logic                 rsp_tuser,    // [0] channel
   output logic                 rsp_tlast,    // last result of this line
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int CMP_W = (VALUE_BITS > CFG_W) ? VALUE_BITS : CFG_W;
   localparam int NUM_W = CFG_W + CC_BITS;

   // parser / line state
   state_type               state_ff, state_in;
   phase_type               phase_ff, phase_in;
   logic [1:0]              comma_cnt_ff, comma_cnt_in;
   logic [VALUE_BITS-1:0]   accum_ff, accum_in;
   logic                    neg_ff, neg_in;
   logic [VALUE_BITS-1:0]   first_val_ff, first_val_in;
   logic                    first_neg_ff, first_neg_in;
   // configuration
   logic [CFG_W-1:0]        min_ff, min_in;
   logic [CFG_W-1:0]        max_ff, max_in;
   // scaling sequencer
   logic                    pend0_ff, pend0_in;
   logic                    pend1_ff, pend1_in;
   logic                    chan_ff, chan_in;
   logic [CFG_W-1:0]        diff_ff, diff_in;
   logic [CFG_W-1:0]        span_ff, span_in;
   logic [CFG_W-1:0]        rem_ff, rem_in;
   logic [CC_BITS-1:0]      qsr_ff, qsr_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CC_BITS-1:0]      rsp_cc_ff, rsp_cc_in;
   logic                    rsp_chan_ff, rsp_chan_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_fire;
   logic                    csr_fire;
   logic                    is_digit;
   logic [3:0]              digit;
   logic [VALUE_BITS+3:0]   acc_next;
   logic [CMP_W-1:0]        min_ext, max_ext, first_ext, accum_ext, op_ext, sub_ext;
   logic                    rep0, rep1;
   logic [NUM_W-1:0]        num;
   logic [CFG_W:0]          trial;
   logic                    qbit;
   logic                    clear_line;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cc_ff};
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tlast  = rsp_last_ff;

   // decimal accumulate: accum*10 + digit, saturated below
   assign is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign digit    = 4'(req_tdata - CH_ZERO);
   assign acc_next = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1)
                     + (VALUE_BITS+4)'(digit);

   assign min_ext   = CMP_W'(min_ff);
   assign max_ext   = CMP_W'(max_ff);
   assign first_ext = CMP_W'(first_val_ff);
   assign accum_ext = CMP_W'(accum_ff);
   assign op_ext    = chan_ff ? accum_ext : first_ext;
   assign sub_ext   = op_ext - min_ext;

   // a field is reported when its line has exactly one comma and the field is positive and above the threshold
   assign rep0 = (comma_cnt_ff == 2'd1) && !first_neg_ff && (first_ext > min_ext);
   assign rep1 = (comma_cnt_ff == 2'd1) && !neg_ff && (accum_ext > min_ext);

   // diff*127 = (diff << 7) - diff
   assign num = {diff_ff, {CC_BITS{1'b0}}} - NUM_W'(diff_ff);

   // one restoring-division step
   assign trial = {rem_ff, qsr_ff[CC_BITS-1]};
   assign qbit  = (trial >= {1'b0, span_ff});

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      comma_cnt_in = comma_cnt_ff;
      accum_in     = accum_ff;
      neg_in       = neg_ff;
      first_val_in = first_val_ff;
      first_neg_in = first_neg_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      pend0_in     = pend0_ff;
      pend1_in     = pend1_ff;
      chan_in      = chan_ff;
      diff_in      = diff_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      qsr_in       = qsr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cc_in    = rsp_cc_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;
      clear_line   = 1'b0;

      if (csr_fire) begin
         if (csr_index == CSR_MIN) begin
            min_in = csr_data;
         end else if (csr_index == CSR_MAX) begin
            max_in = csr_data;
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_tdata == CH_LF) begin
                  if (rep0 || rep1) begin
                     pend0_in = rep0;
                     pend1_in = rep1;
                     chan_in  = !rep0;
                     state_in = ST_PREP;
                  end else begin
                     clear_line = 1'b1;
                  end
               end else if (req_tdata == CH_COMMA) begin
                  if (comma_cnt_ff == 2'd0) begin
                     first_val_in = accum_ff;
                     first_neg_in = neg_ff;
                  end
                  if (comma_cnt_ff != 2'd2) begin
                     comma_cnt_in = comma_cnt_ff + 2'd1;
                  end
                  accum_in = '0;
                  neg_in   = 1'b0;
                  phase_in = PH_LEAD;
               end else if (phase_ff == PH_LEAD && req_tdata == CH_SPACE) begin
                  // leading space: skipped
               end else if (phase_ff == PH_LEAD && req_tdata == CH_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = PH_SIGN;
               end else if (phase_ff == PH_STOP) begin
                  // field done, rest ignored
               end else if (is_digit) begin
                  accum_in = (|acc_next[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                                 : acc_next[VALUE_BITS-1:0];
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_STOP;
               end
            end
         end
         ST_PREP: begin
            span_in = max_ff - min_ff;
            diff_in = sub_ext[CFG_W-1:0];
            if (max_ff <= min_ff) begin
               qsr_in   = '0;
               state_in = ST_EMIT;
            end else if (op_ext >= max_ext) begin
               qsr_in   = CC_TOP;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // quotient < 128, so the top bits are already below span
            rem_in   = num[NUM_W-1:CC_BITS];
            qsr_in   = num[CC_BITS-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? CFG_W'(trial - {1'b0, span_ff}) : trial[CFG_W-1:0];
            qsr_in = {qsr_ff[CC_BITS-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_cc_in    = qsr_ff;
               rsp_chan_in  = chan_ff;
               rsp_last_in  = chan_ff || !pend1_ff;
               if (!chan_ff && pend1_ff) begin
                  chan_in  = 1'b1;
                  state_in = ST_PREP;
               end else begin
                  pend0_in   = 1'b0;
                  pend1_in   = 1'b0;
                  clear_line = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clear_line) begin
         phase_in     = PH_LEAD;
         comma_cnt_in = 2'd0;
         accum_in     = '0;
         neg_in       = 1'b0;
         first_val_in = '0;
         first_neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LEAD;
         comma_cnt_ff <= 2'd0;
         accum_ff     <= '0;
         neg_ff       <= 1'b0;
         first_val_ff <= '0;
         first_neg_ff <= 1'b0;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         pend0_ff     <= 1'b0;
         pend1_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         comma_cnt_ff <= comma_cnt_in;
         accum_ff     <= accum_in;
         neg_ff       <= neg_in;
         first_val_ff <= first_val_in;
         first_neg_ff <= first_neg_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         pend0_ff     <= pend0_in;
         pend1_ff     <= pend1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      diff_ff     <= diff_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      qsr_ff      <= qsr_in;
      cnt_ff      <= cnt_in;
      rsp_cc_ff   <= rsp_cc_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_last_ff <= rsp_last_in;
   end

   // a new result only comes from the load step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside load step");

   // a line feed leaves the line cleared unless scaling started
   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tdata == CH_LF) |=>
         (state_ff != ST_IDLE) || (comma_cnt_ff == 2'd0 && phase_ff == PH_LEAD))
      else $error("line state not cleared after line feed");

   // the channel being loaded must be one that was flagged for report
   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (chan_ff ? pend1_ff : pend0_ff))
      else $error("emitting an unreported channel");

endmodule
